// ----- rtl/crcbu_pkg.sv -----
// Shared constants and types for the byte-wise CRC engine.
package crcbu_pkg;

    localparam int unsigned CRC_W  = 32;
    localparam int unsigned HALF_W = 16;
    localparam int unsigned BYTE_W = 8;

    typedef logic [1:0]        t_mode;
    typedef logic [CRC_W-1:0]  t_crc;
    typedef logic [HALF_W-1:0] t_crc16;
    typedef logic [BYTE_W-1:0] t_byte;

    // Mode codes; the code with both bits set behaves as the 32-bit mode.
    localparam t_mode MODE_MSB16 = 2'd0;
    localparam t_mode MODE_REF16 = 2'd1;
    localparam t_mode MODE_REF32 = 2'd2;

    localparam t_crc16 POLY_MSB16 = 16'h1021;
    localparam t_crc16 POLY_REF16 = 16'hA001;
    localparam t_crc   POLY_REF32 = 32'hEDB8_8320;

endpackage

// ----- rtl/crcbu_in_if.sv -----
// Input request channel: one message byte per request.
interface crcbu_in_if;
    logic                 valid;
    logic                 ready;
    crcbu_pkg::t_byte     data_byte;
    logic                 last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- rtl/crcbu_out_if.sv -----
// Result channel: running CRC after each byte.
interface crcbu_out_if;
    logic                 valid;
    logic                 ready;
    crcbu_pkg::t_crc      crc_value;
    logic                 message_done;

    modport source (output valid, output crc_value, output message_done, input ready);
    modport sink   (input valid, input crc_value, input message_done, output ready);
endinterface

// ----- rtl/crcbu_fold.sv -----
// Unrolled eight-bit CRC update for all three modes.
module crcbu_fold (
    input  crcbu_pkg::t_mode i_mode,
    input  crcbu_pkg::t_crc  i_crc,
    input  crcbu_pkg::t_byte i_byte,
    output crcbu_pkg::t_crc  o_crc
);

    crcbu_pkg::t_crc16 w_msb;
    crcbu_pkg::t_crc16 w_r16;
    crcbu_pkg::t_crc   w_r32;

    // MSB-first 16-bit
    always_comb begin
        w_msb = i_crc[crcbu_pkg::HALF_W-1:0] ^ {i_byte, 8'h00};
        for (int k = 0; k < crcbu_pkg::BYTE_W; k++) begin
            if (w_msb[crcbu_pkg::HALF_W-1]) begin
                w_msb = {w_msb[crcbu_pkg::HALF_W-2:0], 1'b0} ^ crcbu_pkg::POLY_MSB16;
            end else begin
                w_msb = {w_msb[crcbu_pkg::HALF_W-2:0], 1'b0};
            end
        end
    end

    // reflected 16-bit
    always_comb begin
        w_r16 = i_crc[crcbu_pkg::HALF_W-1:0] ^ {8'h00, i_byte};
        for (int k = 0; k < crcbu_pkg::BYTE_W; k++) begin
            if (w_r16[0]) begin
                w_r16 = {1'b0, w_r16[crcbu_pkg::HALF_W-1:1]} ^ crcbu_pkg::POLY_REF16;
            end else begin
                w_r16 = {1'b0, w_r16[crcbu_pkg::HALF_W-1:1]};
            end
        end
    end

    // reflected 32-bit
    always_comb begin
        w_r32 = i_crc ^ {24'h000000, i_byte};
        for (int k = 0; k < crcbu_pkg::BYTE_W; k++) begin
            if (w_r32[0]) begin
                w_r32 = {1'b0, w_r32[crcbu_pkg::CRC_W-1:1]} ^ crcbu_pkg::POLY_REF32;
            end else begin
                w_r32 = {1'b0, w_r32[crcbu_pkg::CRC_W-1:1]};
            end
        end
    end

    always_comb begin
        case (i_mode)
            crcbu_pkg::MODE_MSB16: o_crc = {16'h0000, w_msb};
            crcbu_pkg::MODE_REF16: o_crc = {16'h0000, w_r16};
            default:               o_crc = w_r32;
        endcase
    end

endmodule

// ----- rtl/crc_byte_update_multi.sv -----
// An accepted request is held in the input register, then in the result register.
// Throughput: one byte per cycle while o_rsp.ready holds; the running CRC updates in the same cycle
//   the result register loads, so consecutive bytes chain without bubbles.
// The combinational byte fold between input and result register sets the rate.
// Reset (i_rst_n low, synchronous): both stages empty, running CRC zero, mode 0.
// Top level: input stage, CRC fold, result stage and the mode register.
module crc_byte_update_multi (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  crcbu_pkg::t_mode i_cfg_wr_data,
    crcbu_in_if.sink         i_req,
    crcbu_out_if.source      o_rsp
);

    // mode register
    crcbu_pkg::t_mode r_mode;

    // input stage: holds one accepted request
    logic             r_in_valid;
    crcbu_pkg::t_byte r_in_byte;
    logic             r_in_last;

    // running CRC, chained across bytes of a message
    crcbu_pkg::t_crc  r_run_crc;
    crcbu_pkg::t_crc  n_run_crc;

    // result stage
    logic             r_out_valid;
    crcbu_pkg::t_crc  r_out_crc;
    logic             r_out_done;

    crcbu_pkg::t_crc  w_fold;
    logic             w_adv;      // result stage can take the held request
    logic             w_in_take;  // request accepted this edge

    // result stage is free, or its content leaves this cycle
    assign w_adv     = !r_out_valid || o_rsp.ready;
    // input stage frees whenever its request moves on
    assign i_req.ready = !r_in_valid || w_adv;
    assign w_in_take = i_req.valid && i_req.ready;

    crcbu_fold u_fold (
        .i_mode (r_mode),
        .i_crc  (r_run_crc),
        .i_byte (r_in_byte),
        .o_crc  (w_fold)
    );

    // a closing byte restarts the chain from zero
    assign n_run_crc = r_in_last ? '0 : w_fold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= crcbu_pkg::MODE_MSB16;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_req.data_byte;
            r_in_last <= i_req.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_crc <= '0;
        end else if (r_in_valid && w_adv) begin
            r_run_crc <= n_run_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && w_adv) begin
            r_out_crc  <= w_fold;
            r_out_done <= r_in_last;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.crc_value    = r_out_crc;
    assign o_rsp.message_done = r_out_done;

`ifndef ASSERT_OFF
    // closing byte clears the chain
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && w_adv && r_in_last |=> r_run_crc == '0)
        else $error("running CRC not cleared after last byte");

    // 16-bit modes leave the upper half of the result zero
    a_half_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && w_adv &&
        (r_mode == crcbu_pkg::MODE_MSB16 || r_mode == crcbu_pkg::MODE_REF16)
        |=> o_rsp.crc_value[31:16] == 16'h0000)
        else $error("upper CRC half nonzero in 16-bit mode");

    // a stalled input stage must not take another request
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |-> !i_req.ready)
        else $error("input stage overrun");

    // every moved request lands in the result stage
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && w_adv |=> o_rsp.valid)
        else $error("result lost");
`endif

endmodule
